// ===== hw/rtl/sbrc_pkg.sv =====
// Shared types, constants and opcodes for the sixteen-bit register CPU.
`timescale 1ns / 1ps

package sbrc_pkg;

   // Data path and storage sizes
   localparam int WORD_W    = 16;
   localparam int REG_CNT   = 16;
   localparam int REG_IW    = $clog2(REG_CNT);
   localparam int MEM_WORDS = 64;
   localparam int MEM_AW    = $clog2(MEM_WORDS);
   localparam int OPER_W    = 2;
   localparam int LDADDR_W  = 6;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [REG_IW-1:0] reg_idx_type;
   typedef logic [MEM_AW-1:0] mem_addr_type;
   typedef logic [OPER_W-1:0] oper_type;
   typedef logic [3:0]        opcode_type;

   localparam reg_idx_type  PC_IDX   = reg_idx_type'(REG_CNT - 1);
   localparam mem_addr_type ADDR_ONE = mem_addr_type'(1);

   // Transaction operation codes
   localparam oper_type OPER_LOAD  = 2'd0;
   localparam oper_type OPER_START = 2'd1;
   localparam oper_type OPER_EXEC  = 2'd2;

   // Instruction opcodes, ir[15:12]
   localparam opcode_type OPC_HALT  = 4'h0;
   localparam opcode_type OPC_ADD   = 4'h1;
   localparam opcode_type OPC_SUB   = 4'h2;
   localparam opcode_type OPC_LOAD  = 4'h3;
   localparam opcode_type OPC_STORE = 4'h4;
   localparam opcode_type OPC_SETLO = 4'h5;
   localparam opcode_type OPC_SETHI = 4'h6;
   localparam opcode_type OPC_MOVE  = 4'h7;
   localparam opcode_type OPC_JABS  = 4'h8;
   localparam opcode_type OPC_JREL  = 4'h9;
   localparam opcode_type OPC_BZ    = 4'hA;
   localparam opcode_type OPC_OUT   = 4'hE;

   // Outcome of one instruction, from the execute unit to the core
   typedef struct packed {
      logic         halt;
      logic         wb_en;
      reg_idx_type  wb_idx;
      word_type     wb_data;
      word_type     pc_new;
      logic         st_en;
      mem_addr_type st_addr;
      word_type     st_data;
      logic         out_en;
      word_type     out_value;
      logic         is_load;
      mem_addr_type ld_addr;
   } exec_result_type;

endpackage

// ===== hw/rtl/sbrc_pmem.sv =====
// Program memory: one write port, two registered read ports, per-word valid bits.
`timescale 1ns / 1ps

module sbrc_pmem (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  sbrc_pkg::mem_addr_type wr_addr,
   input  sbrc_pkg::word_type     wr_data,
   input  sbrc_pkg::mem_addr_type ra_addr,
   output sbrc_pkg::word_type     ra_data,
   input  sbrc_pkg::mem_addr_type rb_addr,
   output sbrc_pkg::word_type     rb_data
);
   import sbrc_pkg::*;

   word_type               mem_ff [MEM_WORDS];
   logic [MEM_WORDS-1:0]   vld_ff;
   word_type               ra_data_ff;
   word_type               rb_data_ff;

   // Valid bits: a word never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // Storage and registered reads, write data bypassed to a same-address read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (wr_en && (wr_addr == ra_addr)) begin
         ra_data_ff <= wr_data;
      end else if (vld_ff[ra_addr]) begin
         ra_data_ff <= mem_ff[ra_addr];
      end else begin
         ra_data_ff <= '0;
      end
      if (wr_en && (wr_addr == rb_addr)) begin
         rb_data_ff <= wr_data;
      end else if (vld_ff[rb_addr]) begin
         rb_data_ff <= mem_ff[rb_addr];
      end else begin
         rb_data_ff <= '0;
      end
   end

   assign ra_data = ra_data_ff;
   assign rb_data = rb_data_ff;

endmodule

// ===== hw/rtl/sbrc_alu.sv =====
// Instruction decode and execute: register values in, write-back and next PC out.
`timescale 1ns / 1ps

module sbrc_alu (
   input  sbrc_pkg::word_type        ir,
   input  sbrc_pkg::word_type        nxt_word,
   input  sbrc_pkg::word_type        pc_inc,
   input  sbrc_pkg::word_type        r1_val,
   input  sbrc_pkg::word_type        r2_val,
   input  sbrc_pkg::word_type        r3_val,
   output sbrc_pkg::exec_result_type res
);
   import sbrc_pkg::*;

   opcode_type opcode;
   logic [7:0] imm;
   word_type   mag;
   word_type   offs;
   word_type   sum23;

   assign opcode = ir[15:12];
   assign imm    = ir[7:0];
   assign sum23  = r2_val + r3_val;

   // Sign-magnitude offset minus one: negative gives -mag-1, positive mag-1
   assign mag  = {{(WORD_W-7){1'b0}}, imm[6:0]};
   assign offs = imm[7] ? ~mag : (mag - 16'd1);

   always_comb begin
      res           = '0;
      res.wb_idx    = ir[11:8];
      res.pc_new    = pc_inc;
      res.st_addr   = sum23[MEM_AW-1:0];
      res.st_data   = r1_val;
      res.ld_addr   = sum23[MEM_AW-1:0];
      unique case (opcode)
         OPC_HALT: begin
            res.halt = 1'b1;
         end
         OPC_ADD: begin
            res.wb_en   = 1'b1;
            res.wb_data = sum23;
         end
         OPC_SUB: begin
            res.wb_en   = 1'b1;
            res.wb_data = r2_val - r3_val;
         end
         OPC_LOAD: begin
            res.is_load = 1'b1;
         end
         OPC_STORE: begin
            res.st_en = 1'b1;
         end
         OPC_SETLO: begin
            res.wb_en   = 1'b1;
            res.wb_data = {r1_val[15:8], imm};
         end
         OPC_SETHI: begin
            res.wb_en   = 1'b1;
            res.wb_data = {imm, r1_val[7:0]};
         end
         OPC_MOVE: begin
            res.wb_en   = 1'b1;
            res.wb_data = r2_val;
         end
         OPC_JABS: begin
            res.pc_new = nxt_word;
         end
         OPC_JREL: begin
            res.pc_new = pc_inc + r1_val + offs;
         end
         OPC_BZ: begin
            if (r1_val == '0) begin
               res.pc_new = pc_inc + offs;
            end
         end
         OPC_OUT: begin
            res.out_en    = 1'b1;
            res.out_value = r1_val;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== hw/rtl/sixteen_bit_register_cpu.sv =====
// Top level: stream ports, register file, load sequencing and result register.
`timescale 1ns / 1ps

// A small 16-bit CPU driven one transaction at a time: each request loads a
// program word, starts the CPU at address zero, or executes one instruction,
// and each request yields exactly one response carrying the output-port value,
// the halt flag and r15 (the PC). Requests are taken one per cycle when the
// response register is free and no memory load is issuing its data read; a
// request passes through the input register and then the response register.
// The instruction at the PC and the word after it are read ahead from program
// memory every cycle, so most instructions execute without a wait. The
// memory-load instruction (opcode 3) is the exception, because its data word
// comes through a registered read port of the 64-word program memory; it first
// issues that read, and the input stalls while it does.
// Registers and memory are zero after reset and the CPU waits halted until a
// start transaction.
module sixteen_bit_register_cpu (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // operation[1:0], load_address[7:2], load_data[23:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // out_valid[0], out_value[16:1], halted[17],
                                    // program_counter[33:18], zero fill
);
   import sbrc_pkg::*;

   // Input register
   logic                in_valid_ff;
   oper_type            in_oper_ff;
   logic [LDADDR_W-1:0] in_addr_ff;
   word_type            in_data_ff;

   // CPU state
   word_type     regs_ff [REG_CNT];
   word_type     regs_in [REG_CNT];
   logic         halted_ff;
   logic         halted_in;
   logic         ld_wait_ff;
   reg_idx_type  ld_dst_ff;
   mem_addr_type ld_addr_ff;

   // Result register
   logic     rsp_valid_ff;
   logic     rsp_out_valid_ff;
   word_type rsp_out_value_ff;
   logic     rsp_halted_ff;
   word_type rsp_pc_ff;

   // Memory ports
   logic         wr_en;
   mem_addr_type wr_addr;
   word_type     wr_data;
   mem_addr_type ra_addr;
   mem_addr_type rb_addr;
   word_type     ir;
   word_type     nxt_word;

   // Execute path
   word_type        pc_inc;
   reg_idx_type     r1_idx;
   reg_idx_type     r2_idx;
   reg_idx_type     r3_idx;
   word_type        r1_val;
   word_type        r2_val;
   word_type        r3_val;
   exec_result_type res;
   logic            room;
   logic            run;
   logic            ld_first;
   logic            fire;
   logic            out_en;
   word_type        out_value;
   word_type        pc_next;

   sbrc_pmem u_pmem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .ra_addr (ra_addr),
      .ra_data (ir),
      .rb_addr (rb_addr),
      .rb_data (nxt_word)
   );

   // Register reads; r15 reads as the already incremented PC
   assign pc_inc = regs_ff[PC_IDX] + 16'd1;
   assign r1_idx = ir[11:8];
   assign r2_idx = ir[7:4];
   assign r3_idx = ir[3:0];
   assign r1_val = (r1_idx == PC_IDX) ? pc_inc : regs_ff[r1_idx];
   assign r2_val = (r2_idx == PC_IDX) ? pc_inc : regs_ff[r2_idx];
   assign r3_val = (r3_idx == PC_IDX) ? pc_inc : regs_ff[r3_idx];

   sbrc_alu u_alu (
      .ir       (ir),
      .nxt_word (nxt_word),
      .pc_inc   (pc_inc),
      .r1_val   (r1_val),
      .r2_val   (r2_val),
      .r3_val   (r3_val),
      .res      (res)
   );

   // Handshake: a memory load first issues its data read before it can complete
   assign room       = !rsp_valid_ff || rsp_tready;
   assign run        = in_valid_ff && (in_oper_ff == OPER_EXEC) && !halted_ff;
   assign ld_first   = run && !ld_wait_ff && res.is_load;
   assign fire       = in_valid_ff && room && !ld_first;
   assign req_tready = !in_valid_ff || fire;

   // Next state of registers, halt flag and memory write
   always_comb begin
      regs_in   = regs_ff;
      halted_in = halted_ff;
      wr_en     = 1'b0;
      wr_addr   = res.st_addr;
      wr_data   = res.st_data;
      out_en    = 1'b0;
      out_value = '0;
      if (ld_first) begin
         regs_in[PC_IDX] = pc_inc;
      end else if (fire) begin
         unique case (in_oper_ff)
            OPER_LOAD: begin
               wr_en   = 1'b1;
               wr_addr = in_addr_ff[MEM_AW-1:0];
               wr_data = in_data_ff;
            end
            OPER_START: begin
               halted_in       = 1'b0;
               regs_in[PC_IDX] = '0;
            end
            OPER_EXEC: begin
               if (!halted_ff) begin
                  if (ld_wait_ff) begin
                     regs_in[ld_dst_ff] = nxt_word;
                  end else begin
                     regs_in[PC_IDX] = res.pc_new;
                     if (res.wb_en) begin
                        regs_in[res.wb_idx] = res.wb_data;
                     end
                     if (res.halt) begin
                        halted_in = 1'b1;
                     end
                     wr_en     = res.st_en;
                     out_en    = res.out_en;
                     out_value = res.out_value;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign pc_next = regs_in[PC_IDX];

   // Read ahead at the next PC; a pending load keeps port B on its address
   assign ra_addr = pc_next[MEM_AW-1:0];
   always_comb begin
      if (ld_first) begin
         rb_addr = res.ld_addr;
      end else if (ld_wait_ff && !fire) begin
         rb_addr = ld_addr_ff;
      end else begin
         rb_addr = pc_next[MEM_AW-1:0] + ADDR_ONE;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         halted_ff    <= 1'b1;
         ld_wait_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < REG_CNT; i++) begin
            regs_ff[i] <= '0;
         end
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         halted_ff <= halted_in;
         if (ld_first) begin
            ld_wait_ff <= 1'b1;
         end else if (fire) begin
            ld_wait_ff <= 1'b0;
         end
         if (fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         regs_ff <= regs_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_oper_ff <= req_tdata[1:0];
         in_addr_ff <= req_tdata[7:2];
         in_data_ff <= req_tdata[23:8];
      end
      if (ld_first) begin
         ld_dst_ff  <= r1_idx;
         ld_addr_ff <= res.ld_addr;
      end
      if (fire) begin
         rsp_out_valid_ff <= out_en;
         rsp_out_value_ff <= out_value;
         rsp_halted_ff    <= halted_in;
         rsp_pc_ff        <= pc_next;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_pc_ff, rsp_halted_ff, rsp_out_value_ff, rsp_out_valid_ff};

endmodule

// ===== sim/tb_sixteen_bit_register_cpu.sv =====
// Self-checking testbench for the sixteen-bit register CPU stream block.
`timescale 1ns / 1ps

module tb_sixteen_bit_register_cpu;
   import sbrc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int TARGET_ITEMS = 1000;

   // Codes with no defined function: unused operation, no-op opcode
   localparam oper_type   OPER_SPARE = 2'd3;
   localparam opcode_type OPC_SPARE  = 4'hB;

   // Status carried by one response transaction
   typedef struct packed {
      logic     out_valid;
      word_type out_value;
      logic     halted;
      word_type pc;
   } cpu_status_type;

   // Shadow CPU plus the queue of status words still owed by the block
   class cpu_shadow;
      word_type       regs [REG_CNT];
      word_type       memory [MEM_WORDS];
      bit             halted;
      cpu_status_type owed_status [$];
      int             errors;

      function new();
         foreach (regs[i]) regs[i] = '0;
         foreach (memory[i]) memory[i] = '0;
         halted = 1'b1;
         errors = 0;
      endfunction

      function int pending_count();
         return owed_status.size();
      endfunction

      // Advance the shadow by one request; returns 1 if the request did any work
      function bit note_request(oper_type op, logic [LDADDR_W-1:0] addr, word_type data);
         cpu_status_type st;
         word_type       ir;
         word_type       sum;
         word_type       offs;
         opcode_type     opc;
         reg_idx_type    ra;
         reg_idx_type    rb;
         reg_idx_type    rc;
         logic [7:0]     imm;
         bit             active;
         st     = '0;
         active = 1'b1;
         case (op)
            OPER_LOAD: memory[addr % MEM_WORDS] = data;
            OPER_START: begin
               halted       = 1'b0;
               regs[PC_IDX] = '0;
            end
            OPER_EXEC: begin
               if (halted) begin
                  active = 1'b0;
               end else begin
                  // fetch, bump PC, decode
                  ir           = memory[regs[PC_IDX] % MEM_WORDS];
                  regs[PC_IDX] = regs[PC_IDX] + 16'd1;
                  opc = ir[15:12];
                  ra  = ir[11:8];
                  rb  = ir[7:4];
                  rc  = ir[3:0];
                  imm = ir[7:0];
                  // sign-magnitude offset, minus one so it is relative to the instruction
                  if (imm[7])
                     offs = 16'd127 - 16'(imm);
                  else
                     offs = 16'(imm) - 16'd1;
                  sum = regs[rb] + regs[rc];
                  case (opc)
                     OPC_HALT:  halted = 1'b1;
                     OPC_ADD:   regs[ra] = sum;
                     OPC_SUB:   regs[ra] = regs[rb] - regs[rc];
                     OPC_LOAD:  regs[ra] = memory[sum % MEM_WORDS];
                     OPC_STORE: memory[sum % MEM_WORDS] = regs[ra];
                     OPC_SETLO: regs[ra] = {regs[ra][15:8], imm};
                     OPC_SETHI: regs[ra] = {imm, regs[ra][7:0]};
                     OPC_MOVE:  regs[ra] = regs[rb];
                     OPC_JABS:  regs[PC_IDX] = memory[regs[PC_IDX] % MEM_WORDS];
                     OPC_JREL:  regs[PC_IDX] = regs[PC_IDX] + regs[ra] + offs;
                     OPC_BZ: begin
                        if (regs[ra] == '0) regs[PC_IDX] = regs[PC_IDX] + offs;
                     end
                     OPC_OUT: begin
                        st.out_valid = 1'b1;
                        st.out_value = regs[ra];
                     end
                     default: ;
                  endcase
               end
            end
            default: active = 1'b0;
         endcase
         st.halted = halted;
         st.pc     = regs[PC_IDX];
         owed_status.push_back(st);
         return active;
      endfunction

      function void compare_field(string name, word_type want, word_type got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         end
      endfunction

      // Compare one response transaction with the oldest owed status
      function void check_response(logic [39:0] bits);
         cpu_status_type got;
         cpu_status_type want;
         got.out_valid = bits[0];
         got.out_value = bits[16:1];
         got.halted    = bits[17];
         got.pc        = bits[33:18];
         if (owed_status.size() == 0) begin
            errors++;
            $display("%0t: unexpected response: expected none, actual %h", $time, bits);
            return;
         end
         want = owed_status.pop_front();
         compare_field("out_valid", 16'(want.out_valid), 16'(got.out_valid));
         compare_field("out_value", want.out_value, got.out_value);
         compare_field("halted", 16'(want.halted), 16'(got.halted));
         compare_field("program_counter", want.pc, got.pc);
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;   // operation[1:0], load_address[7:2], load_data[23:8]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // out_valid[0], out_value[16:1], halted[17],
                                   // program_counter[33:18], zero fill

   cpu_shadow shadow = new();
   int        send_idle_pct  = 0;
   int        recv_stall_pct = 0;
   int        sent_items     = 0;
   int        cycle_count    = 0;

   sixteen_bit_register_cpu dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) shadow.check_response(rsp_tdata);
   end

   // Drive one request transaction, with an optional idle gap ahead of it
   task automatic send_request(oper_type op, logic [LDADDR_W-1:0] addr, word_type data);
      if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {data, addr, op};
      do @(posedge clock); while (!req_tready);
      void'(shadow.note_request(op, addr, data));
      sent_items++;
   endtask

   // Hold off the sender until every owed response has come back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (shadow.pending_count() != 0) @(posedge clock);
   endtask

   // Mostly well-formed instructions; halt kept rare so programs run a while
   function automatic word_type random_instruction();
      opcode_type opc;
      if ($urandom_range(9) == 0) return word_type'($urandom);
      if ($urandom_range(49) == 0)
         opc = OPC_HALT;
      else
         opc = opcode_type'($urandom_range(1, 15));
      return {opc, 12'($urandom)};
   endfunction

   initial begin
      int prog_idx;
      int prog_len;
      int run_len;
      int pick;
      reset <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: execute and unused operation while halted after reset
      send_request(OPER_EXEC, 6'd0, 16'h0000);
      send_request(OPER_SPARE, 6'h3F, 16'hFFFF);
      // Program touching every opcode, with forward branches and jumps
      send_request(OPER_LOAD, 6'd0,  {OPC_SETLO, 4'd1, 8'hFF});
      send_request(OPER_LOAD, 6'd1,  {OPC_SETHI, 4'd1, 8'h80});
      send_request(OPER_LOAD, 6'd2,  {OPC_ADD,   4'd2, 4'd1, 4'd1});
      send_request(OPER_LOAD, 6'd3,  {OPC_SUB,   4'd3, 4'd0, 4'd1});
      send_request(OPER_LOAD, 6'd4,  {OPC_MOVE,  4'd4, 4'd1, 4'd0});
      send_request(OPER_LOAD, 6'd5,  {OPC_STORE, 4'd1, 4'd2, 4'd3});
      send_request(OPER_LOAD, 6'd6,  {OPC_LOAD,  4'd5, 4'd2, 4'd3});
      send_request(OPER_LOAD, 6'd7,  {OPC_OUT,   4'd5, 8'h00});
      send_request(OPER_LOAD, 6'd8,  {OPC_BZ,    4'd6, 8'h02});
      send_request(OPER_LOAD, 6'd10, {OPC_JREL,  4'd0, 8'h02});
      send_request(OPER_LOAD, 6'd12, {OPC_JABS,  12'h000});
      send_request(OPER_LOAD, 6'd13, 16'h000E);
      send_request(OPER_LOAD, 6'd14, {OPC_SPARE, 12'h000});
      send_request(OPER_START, 6'h3F, 16'hFFFF);
      repeat (13) send_request(OPER_EXEC, 6'd0, 16'h0000);
      // one past the halt: ignored
      send_request(OPER_EXEC, 6'h2A, 16'h5555);
      send_request(OPER_LOAD, 6'h3F, 16'hFFFF);

      // Random programs: load, start, run, with some noise mixed in
      prog_idx = 0;
      while (sent_items < TARGET_ITEMS) begin
         case (prog_idx % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
            default: begin send_idle_pct = 8; recv_stall_pct = 8; end
         endcase
         prog_len = $urandom_range(4, 40);
         for (int i = 0; i < prog_len; i++)
            send_request(OPER_LOAD, LDADDR_W'(i), random_instruction());
         if (prog_idx == 1 || $urandom_range(3) == 0) drain_responses();
         send_request(OPER_START, LDADDR_W'($urandom), word_type'($urandom));
         run_len = $urandom_range(8, 60);
         for (int i = 0; i < run_len; i++) begin
            pick = $urandom_range(99);
            if (pick < 4)
               send_request(OPER_SPARE, LDADDR_W'($urandom), word_type'($urandom));
            else if (pick < 8)
               send_request(OPER_LOAD, LDADDR_W'($urandom), word_type'($urandom));
            else if (pick < 10)
               send_request(OPER_START, LDADDR_W'($urandom), word_type'($urandom));
            else
               send_request(OPER_EXEC, LDADDR_W'($urandom), word_type'($urandom));
         end
         prog_idx++;
      end

      // Let the last responses come back, then a few quiet cycles
      req_tvalid <= 1'b0;
      while (shadow.pending_count() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (shadow.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
